@@ rtl/core/rrc_pkg.sv @@
// ----------------------------------------------------------------------------
// rrc_pkg
// Types, constants and the CRC-16 byte update shared by the read request
// checker modules.
// ----------------------------------------------------------------------------
package rrc_pkg;

  localparam logic [15:0] CrcInit     = 16'hFFFF;
  localparam logic [15:0] CrcPoly     = 16'hA001;
  localparam logic [7:0]  ExcFlag     = 8'h80;
  localparam logic [7:0]  FnCoils     = 8'h01;
  localparam logic [7:0]  FnHolding   = 8'h03;
  localparam logic [7:0]  ResetId     = 8'h01;
  localparam logic [15:0] ResetMaxQty = 16'h07D0;
  localparam logic [15:0] ResetMaxAdr = 16'hFFF9;

  // Depth of the frame queue between the front and the back.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  // Configuration register indices.
  localparam logic [1:0] CfgOwnSlaveId = 2'd0;
  localparam logic [1:0] CfgMaxQty     = 2'd1;
  localparam logic [1:0] CfgMaxAdr     = 2'd2;

  // Exception codes.
  localparam logic [1:0] ExcNone        = 2'd0;
  localparam logic [1:0] ExcIllegalFn   = 2'd1;
  localparam logic [1:0] ExcIllegalAddr = 2'd2;
  localparam logic [1:0] ExcIllegalQty  = 2'd3;

  typedef enum logic [1:0] {
    VERDICT_OK        = 2'd0,
    VERDICT_EXCEPTION = 2'd1,
    VERDICT_IGNORED   = 2'd2
  } verdict_e;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       start_of_frame;
  } in_item_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic [7:0] reply_function;
    logic [1:0] exc_code;
  } out_item_t;

  // One complete frame as handed from the front to the back.
  typedef struct packed {
    logic        crc_ok;
    logic [7:0]  slave_id;
    logic [7:0]  fn_code;
    logic [15:0] start_addr;
    logic [15:0] quantity;
  } frame_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // CRC-16 update over one byte, reflected polynomial, LSB first.
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/core/rrc_front.sv @@
// ----------------------------------------------------------------------------
// rrc_front
// Takes frame bytes, tracks the byte position, runs the CRC and captures the
// header fields; emits one frame record on the eighth byte.
// ----------------------------------------------------------------------------
module rrc_front
  import rrc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  input  in_item_t   in_item_i,
  output logic       rec_valid_o,
  output frame_rec_t rec_o
);

  logic [2:0]  pos_q, pos_d, pos_eff;
  logic [15:0] crc_q, crc_d, crc_eff;
  logic [7:0]  id_q, id_d, fn_q, fn_d, crc_lo_q, crc_lo_d;
  logic [15:0] start_q, start_d, qty_q, qty_d;
  logic        last;
  logic [7:0]  b;

  assign b       = in_item_i.frame_byte;
  assign pos_eff = in_item_i.start_of_frame ? 3'd0 : pos_q;
  assign crc_eff = in_item_i.start_of_frame ? CrcInit : crc_q;
  assign last    = (pos_eff == 3'd7);

  always_comb begin
    pos_d    = pos_q;
    crc_d    = crc_q;
    id_d     = id_q;
    fn_d     = fn_q;
    start_d  = start_q;
    qty_d    = qty_q;
    crc_lo_d = crc_lo_q;
    if (byte_valid_i) begin
      unique case (pos_eff)
        3'd0:    id_d = b;
        3'd1:    fn_d = b;
        3'd2:    start_d[15:8] = b;
        3'd3:    start_d[7:0] = b;
        3'd4:    qty_d[15:8] = b;
        3'd5:    qty_d[7:0] = b;
        3'd6:    crc_lo_d = b;
        default: ;
      endcase
      if (last) begin
        pos_d = 3'd0;
        crc_d = CrcInit;
      end else begin
        pos_d = pos_eff + 3'd1;
        crc_d = (pos_eff < 3'd6) ? crc16_byte(crc_eff, b) : crc_eff;
      end
    end
  end

  assign rec_valid_o      = byte_valid_i && last;
  assign rec_o.crc_ok     = ({b, crc_lo_q} == crc_eff);
  assign rec_o.slave_id   = id_q;
  assign rec_o.fn_code    = fn_q;
  assign rec_o.start_addr = start_q;
  assign rec_o.quantity   = qty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= 3'd0;
      crc_q    <= CrcInit;
      id_q     <= 8'h00;
      fn_q     <= 8'h00;
      start_q  <= 16'h0000;
      qty_q    <= 16'h0000;
      crc_lo_q <= 8'h00;
    end else begin
      pos_q    <= pos_d;
      crc_q    <= crc_d;
      id_q     <= id_d;
      fn_q     <= fn_d;
      start_q  <= start_d;
      qty_q    <= qty_d;
      crc_lo_q <= crc_lo_d;
    end
  end

endmodule

@@ rtl/core/rrc_queue.sv @@
// ----------------------------------------------------------------------------
// rrc_queue
// Short first-in first-out queue of frame records between front and back.
// ----------------------------------------------------------------------------
module rrc_queue
  import rrc_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  input  frame_rec_t    wr_rec_i,
  input  logic          rd_ready_i,
  output frame_rec_t    rd_rec_o,
  output queue_status_t status_o
);

  frame_rec_t               mem_q [QueueDepth];
  logic [QueuePtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]       count_q;
  logic                     do_wr, do_rd;

  assign status_o.full  = (count_q == (QueuePtrW+1)'(QueueDepth));
  assign status_o.empty = (count_q == '0);
  assign do_wr          = wr_valid_i && !status_o.full;
  assign do_rd          = rd_ready_i && !status_o.empty;
  assign rd_rec_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/rrc_back.sv @@
// ----------------------------------------------------------------------------
// rrc_back
// Judges one frame record against the configured limits and holds the
// result in an output register until it is taken.
// ----------------------------------------------------------------------------
module rrc_back
  import rrc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rec_valid_i,
  input  frame_rec_t  rec_i,
  output logic        rec_ready_o,
  input  logic [7:0]  own_slave_id_i,
  input  logic [15:0] max_quantity_i,
  input  logic [15:0] max_address_i,
  input  logic        pop_i,
  output logic        out_valid_o,
  output out_item_t   out_item_o
);

  logic        out_valid_q;
  out_item_t   out_item_q, out_item_d;
  logic [15:0] end_addr;
  logic [1:0]  code;
  logic        take;

  assign end_addr    = rec_i.start_addr + rec_i.quantity;
  assign rec_ready_o = !out_valid_q || pop_i;
  assign take        = rec_valid_i && rec_ready_o;

  always_comb begin
    code = ExcNone;
    if (rec_i.fn_code != FnCoils && rec_i.fn_code != FnHolding) begin
      code = ExcIllegalFn;
    end else if (rec_i.quantity > max_quantity_i) begin
      code = ExcIllegalQty;
    end else if (rec_i.start_addr > max_address_i || end_addr > max_address_i) begin
      code = ExcIllegalAddr;
    end

    out_item_d = '0;
    if (!rec_i.crc_ok || rec_i.slave_id != own_slave_id_i) begin
      out_item_d.verdict = VERDICT_IGNORED;
    end else if (code != ExcNone) begin
      out_item_d.verdict        = VERDICT_EXCEPTION;
      out_item_d.reply_function = ExcFlag + rec_i.fn_code;
      out_item_d.exc_code       = code;
    end else begin
      out_item_d.verdict = VERDICT_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ rtl/core/rtu_read_request_checker_unit.sv @@
// ----------------------------------------------------------------------------
// rtu_read_request_checker_unit
// Checks eight-byte read request frames byte by byte, CRC included, and
// returns one verdict per complete frame.
// ----------------------------------------------------------------------------
// The block takes one frame byte per clock cycle while the frame queue has
// room, with no gaps required, and it keeps taking bytes while a verdict
// waits to be popped. The figure of one byte per cycle is set by the CRC-16
// update of a whole byte, which the front stage performs combinationally.
// The clock edge that accepts the eighth byte of a frame also writes its
// frame record into the frame queue; the back stage judges the record into
// the output register once that register is empty or popped. Push is refused
// (full is high, for every byte) only while the two-entry frame queue is
// full, which happens only when a verdict sits unpopped in the output
// register while the records of two further frames wait behind it.
// Configuration transactions are always accepted and take effect at once;
// they must only be issued while no frame is in flight.
module rtu_read_request_checker_unit
  import rrc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Byte input, queue style.
  input  logic        push,
  output logic        full,
  input  in_item_t    in_item_i,
  // Verdict output, queue style.
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_item_o,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic [7:0]    own_slave_id_q;
  logic [15:0]   max_quantity_q, max_address_q;
  logic          byte_accept;
  logic          frm_valid;
  frame_rec_t    frm_rec, queue_rec;
  queue_status_t queue_status;
  logic          back_ready;
  logic          out_valid;

  // Configuration registers. Unknown indices are dropped silently.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_slave_id_q <= ResetId;
      max_quantity_q <= ResetMaxQty;
      max_address_q  <= ResetMaxAdr;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgOwnSlaveId: own_slave_id_q <= cfg_data_i[7:0];
        CfgMaxQty:     max_quantity_q <= cfg_data_i;
        CfgMaxAdr:     max_address_q  <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  // A byte is accepted whenever the frame queue has room, so the record that
  // the eighth byte produces always finds a free entry.
  assign full        = queue_status.full;
  assign byte_accept = push && !full;

  rrc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_accept),
    .in_item_i    (in_item_i),
    .rec_valid_o  (frm_valid),
    .rec_o        (frm_rec)
  );

  rrc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (frm_valid),
    .wr_rec_i   (frm_rec),
    .rd_ready_i (back_ready),
    .rd_rec_o   (queue_rec),
    .status_o   (queue_status)
  );

  rrc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rec_valid_i    (!queue_status.empty),
    .rec_i          (queue_rec),
    .rec_ready_o    (back_ready),
    .own_slave_id_i (own_slave_id_q),
    .max_quantity_i (max_quantity_q),
    .max_address_i  (max_address_q),
    .pop_i          (pop && out_valid),
    .out_valid_o    (out_valid),
    .out_item_o     (out_item_o)
  );

  assign empty = !out_valid;

`ifndef SYNTHESIS
  // A completed frame must never meet a full queue, or its verdict is lost.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    frm_valid |-> !queue_status.full)
    else $error("frame record produced while the frame queue is full");

  // A new verdict can only appear if a frame record was waiting in the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && $past(empty)) |-> $past(!queue_status.empty))
    else $error("verdict appeared without a queued frame");

  // An empty frame queue must not report a refused push.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    queue_status.empty |-> !full)
    else $error("full raised while the frame queue is empty");
`endif

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the read request checker: drives request frames
// byte by byte, predicts each verdict and compares it field by field.
// ----------------------------------------------------------------------------
// Frames are built with a correct CRC-16 unless a test corrupts one on
// purpose. A byte-level tracker mirrors the block's frame state and its three
// settings, and queues one expected verdict whenever an eighth byte is taken.
// The sender works in bursts with random gaps, the receiver pops on a pattern
// of its own, and one test holds the receiver off long enough to fill the
// block and push back on the byte input.
module testbench;
  import rrc_pkg::*;

  // No named index exists for the spare register slot; writes to it must be
  // ignored by the block.
  localparam logic [1:0] CfgUnused = 2'd3;

  typedef logic [0:7][7:0] req_frame_t;

  typedef enum int {
    RX_FREE,
    RX_RANDOM,
    RX_PATTERN
  } rx_style_e;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  in_item_t    in_item_i;
  logic        empty;
  logic        pop;
  out_item_t   out_item_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  rtu_read_request_checker_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Local copy of the three settings, starting from their reset values.
  logic [7:0]  own_id     = ResetId;
  logic [15:0] qty_limit  = ResetMaxQty;
  logic [15:0] addr_limit = ResetMaxAdr;

  // Local copy of the frame state.
  logic [2:0]  req_pos    = 3'd0;
  logic [15:0] req_crc    = CrcInit;
  logic [7:0]  req_slave  = 8'h00;
  logic [7:0]  req_func   = 8'h00;
  logic [15:0] req_start  = 16'h0000;
  logic [15:0] req_qty    = 16'h0000;
  logic [7:0]  req_crc_lo = 8'h00;

  out_item_t verdicts_due[$];
  int        mismatches = 0;

  // Traffic shaping knobs, changed by the tests.
  int        tx_gap_max     = 4;
  int        tx_burst_left  = 0;
  rx_style_e rx_mode        = RX_FREE;
  int        rx_hold_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard limit on the run, far beyond the slowest correct run.
  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Bit-serial CRC-16, reflected: the data bit enters at the low end.
  function automatic logic [15:0] crc_step(logic [15:0] acc, logic [7:0] data);
    logic fb;
    for (int b = 0; b < 8; b++) begin
      fb  = acc[0] ^ data[b];
      acc = acc >> 1;
      if (fb) begin
        acc = acc ^ CrcPoly;
      end
    end
    return acc;
  endfunction

  function automatic req_frame_t make_frame(logic [7:0] slave, logic [7:0] func,
                                            logic [15:0] start, logic [15:0] count,
                                            bit corrupt);
    req_frame_t  f;
    logic [15:0] crc;
    f[0] = slave;
    f[1] = func;
    f[2] = start[15:8];
    f[3] = start[7:0];
    f[4] = count[15:8];
    f[5] = count[7:0];
    crc  = CrcInit;
    for (int i = 0; i < 6; i++) begin
      crc = crc_step(crc, f[i]);
    end
    if (corrupt) begin
      crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    end
    f[6] = crc[7:0];
    f[7] = crc[15:8];
    return f;
  endfunction

  // Follows one accepted byte through the frame state. On the eighth byte
  // the verdict is worked out and queued, and the state starts over.
  function automatic void track_request_byte(logic [7:0] data, logic mark);
    out_item_t   v;
    logic [1:0]  code;
    logic [15:0] end_addr;
    if (mark) begin
      req_pos = 3'd0;
      req_crc = CrcInit;
    end
    case (req_pos)
      3'd0: req_slave = data;
      3'd1: req_func = data;
      3'd2: req_start[15:8] = data;
      3'd3: req_start[7:0] = data;
      3'd4: req_qty[15:8] = data;
      3'd5: req_qty[7:0] = data;
      3'd6: req_crc_lo = data;
      default: ;
    endcase
    if (req_pos < 3'd6) begin
      req_crc = crc_step(req_crc, data);
    end
    if (req_pos != 3'd7) begin
      req_pos = req_pos + 3'd1;
    end else begin
      v        = '0;
      code     = ExcNone;
      end_addr = req_start + req_qty;
      if ({data, req_crc_lo} != req_crc || req_slave != own_id) begin
        v.verdict = VERDICT_IGNORED;
      end else begin
        if (req_func != FnCoils && req_func != FnHolding) begin
          code = ExcIllegalFn;
        end else if (req_qty > qty_limit) begin
          code = ExcIllegalQty;
        end else if (req_start > addr_limit || end_addr > addr_limit) begin
          code = ExcIllegalAddr;
        end
        if (code != ExcNone) begin
          v.verdict        = VERDICT_EXCEPTION;
          v.reply_function = ExcFlag + req_func;
          v.exc_code       = code;
        end
      end
      verdicts_due.push_back(v);
      req_pos = 3'd0;
      req_crc = CrcInit;
    end
  endfunction

  // Offers one byte and returns at the edge where the transaction happens.
  // Push is left high so that a following byte can go out without a gap.
  task automatic send_byte(input logic [7:0] data, input logic mark);
    int gap;
    if (tx_burst_left == 0) begin
      tx_burst_left = $urandom_range(1, 12);
      if (tx_gap_max > 0) begin
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
          push <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
    tx_burst_left--;
    push      <= 1'b1;
    in_item_i <= '{frame_byte: data, start_of_frame: mark};
    do @(posedge clk_i); while (full);
    track_request_byte(data, mark);
  endtask

  task automatic send_frame(input req_frame_t f, input logic mark);
    for (int i = 0; i < 8; i++) begin
      send_byte(f[i], (i == 0) ? mark : 1'b0);
    end
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 7);
    for (int i = 0; i < n; i++) begin
      send_byte(8'($urandom), (i == 0) ? 1'($urandom_range(0, 1))
                                        : 1'($urandom_range(0, 15) == 0));
    end
  endtask

  // Stops the byte stream and lets every expected verdict come out.
  task automatic wait_idle();
    push <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Leaves valid high so that a following write may share the next edge.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgOwnSlaveId: own_id = data[7:0];
      CfgMaxQty:     qty_limit = data;
      CfgMaxAdr:     addr_limit = data;
      default: ;
    endcase
  endtask

  // All three registers plus the spare slot; the slave id goes out with
  // random upper bits, which the block must drop.
  task automatic apply_settings(input logic [7:0] slave, input logic [15:0] qmax,
                                input logic [15:0] amax);
    logic [7:0] junk;
    junk = 8'($urandom);
    wait_idle();
    write_reg(CfgOwnSlaveId, {junk, slave});
    write_reg(CfgUnused, 16'($urandom));
    write_reg(CfgMaxQty, qmax);
    write_reg(CfgMaxAdr, amax);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_random_request(input logic mark);
    logic [7:0]  slave;
    logic [7:0]  func;
    logic [15:0] count;
    logic [15:0] start;
    slave = ($urandom_range(0, 7) != 0) ? own_id : 8'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      func = 8'($urandom);
    end else begin
      func = ($urandom_range(0, 1) != 0) ? FnCoils : FnHolding;
    end
    case ($urandom_range(0, 5))
      0: count = '0;
      1: count = qty_limit;
      2: count = qty_limit + 16'd1;
      3: count = 16'($urandom_range(0, qty_limit));
      4: count = 16'($urandom);
      default: count = 16'($urandom_range(0, 125));
    endcase
    case ($urandom_range(0, 5))
      0: start = '0;
      1: start = addr_limit - count;
      2: start = addr_limit - count + 16'd1;
      3: start = 16'($urandom);
      4: start = 16'($urandom_range(0, addr_limit));
      default: start = 16'hFFFF - 16'($urandom_range(0, 40));
    endcase
    send_frame(make_frame(slave, func, start, count, $urandom_range(0, 9) == 0), mark);
  endtask

  // Result side: pops on the selected pattern, or holds off for a counted
  // stretch when a test asks for it.
  initial begin
    int unsigned beat;
    beat = 0;
    pop  = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      beat++;
      if (rx_hold_cycles > 0) begin
        pop <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk_i);
        rx_hold_cycles = 0;
      end
      case (rx_mode)
        RX_RANDOM:  pop <= ($urandom_range(0, 3) != 0);
        RX_PATTERN: pop <= ((beat % 7) >= 3);
        default:    pop <= 1'b1;
      endcase
    end
  end

  // Every popped verdict is held against the oldest expectation.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && pop && !empty) begin
      if (verdicts_due.size() == 0) begin
        $error("verdict popped with none expected: %p", out_item_o);
        mismatches++;
      end else begin
        want = verdicts_due.pop_front();
        if (out_item_o.verdict !== want.verdict) begin
          $error("verdict: expected %0d, got %0d", want.verdict, out_item_o.verdict);
          mismatches++;
        end
        if (out_item_o.reply_function !== want.reply_function) begin
          $error("reply_function: expected %0h, got %0h",
                 want.reply_function, out_item_o.reply_function);
          mismatches++;
        end
        if (out_item_o.exc_code !== want.exc_code) begin
          $error("exc_code: expected %0d, got %0d",
                 want.exc_code, out_item_o.exc_code);
          mismatches++;
        end
      end
    end
  end

  // Settings straight out of reset: zero quantity, both limits met exactly,
  // one over each limit, and an end address that wraps back below the limit.
  task automatic test_reset_settings();
    tx_gap_max = 3;
    rx_mode    = RX_FREE;
    send_frame(make_frame(ResetId, FnHolding, 16'h0000, 16'h0000, 0), 1'b1);
    send_frame(make_frame(ResetId, FnCoils, ResetMaxAdr - ResetMaxQty, ResetMaxQty, 0),
               1'b1);
    send_frame(make_frame(ResetId, FnHolding, 16'h0000, ResetMaxQty + 16'd1, 0), 1'b1);
    send_frame(make_frame(ResetId, FnCoils, ResetMaxAdr + 16'd1, 16'h0000, 0), 1'b1);
    send_frame(make_frame(ResetId, FnHolding, 16'hFFF0, 16'h0020, 0), 1'b1);
    wait_idle();
  endtask

  // Each exception code, the reply function wrapping past 0xFF, and the
  // priority order: function before quantity before address.
  task automatic test_exception_codes();
    rx_mode = RX_PATTERN;
    apply_settings(8'h5A, 16'd100, 16'd1000);
    send_frame(make_frame(8'h5A, 8'h04, 16'd10, 16'd10, 0), 1'b1);
    send_frame(make_frame(8'h5A, 8'hFF, 16'd10, 16'd10, 0), 1'b1);
    send_frame(make_frame(8'h5A, 8'h00, 16'hFFFF, 16'hFFFF, 0), 1'b1);
    send_frame(make_frame(8'h5A, FnHolding, 16'd2000, 16'd101, 0), 1'b1);
    send_frame(make_frame(8'h5A, FnCoils, 16'd950, 16'd50, 0), 1'b1);
    send_frame(make_frame(8'h5A, FnCoils, 16'd951, 16'd50, 0), 1'b1);
    send_frame(make_frame(8'h5A, FnHolding, 16'hFFF0, 16'h0020, 0), 1'b1);
    wait_idle();
  endtask

  // Bad CRC or a foreign slave id wins over any exception.
  task automatic test_ignored_frames();
    rx_mode = RX_RANDOM;
    send_frame(make_frame(own_id, FnHolding, 16'd1, 16'd1, 1), 1'b1);
    send_frame(make_frame(own_id + 8'd1, FnHolding, 16'd1, 16'd1, 0), 1'b1);
    send_frame(make_frame(own_id ^ 8'h80, 8'h2B, 16'd1, 16'd1, 0), 1'b1);
    send_frame(make_frame(own_id, 8'h2B, 16'hFFFF, 16'hFFFF, 1), 1'b1);
    wait_idle();
  endtask

  // Start mark in the middle of a frame, frames with no start mark at all,
  // and a stream that falls out of step and is brought back by a mark.
  task automatic test_framing();
    req_frame_t f;
    rx_mode = RX_FREE;
    f = make_frame(own_id, FnCoils, 16'd5, 16'd5, 0);
    for (int i = 0; i < 3; i++) begin
      send_byte(f[i], i == 0);
    end
    send_frame(make_frame(own_id, FnHolding, 16'd7, 16'd3, 0), 1'b1);
    send_frame(make_frame(own_id, 8'h06, 16'd7, 16'd3, 0), 1'b0);
    for (int i = 0; i < 5; i++) begin
      send_byte(f[i], 1'b0);
    end
    send_frame(f, 1'b0);
    send_frame(make_frame(own_id, FnCoils, 16'd0, 16'd1, 0), 1'b1);
    wait_idle();
  endtask

  // Smallest and largest values of every register.
  task automatic test_setting_extremes();
    rx_mode = RX_PATTERN;
    apply_settings(8'h00, 16'h0000, 16'h0000);
    send_frame(make_frame(8'h00, FnCoils, 16'h0000, 16'h0000, 0), 1'b1);
    send_frame(make_frame(8'h00, FnCoils, 16'h0000, 16'h0001, 0), 1'b1);
    send_frame(make_frame(8'h00, FnHolding, 16'h0001, 16'h0000, 0), 1'b1);
    apply_settings(8'hFF, 16'hFFFF, 16'hFFFF);
    send_frame(make_frame(8'hFF, FnHolding, 16'h0000, 16'hFFFF, 0), 1'b1);
    send_frame(make_frame(8'hFF, FnCoils, 16'h0001, 16'hFFFF, 0), 1'b1);
    send_frame(make_frame(8'hFF, FnCoils, 16'hFFFF, 16'h0000, 0), 1'b1);
    send_frame(make_frame(8'h00, FnCoils, 16'h0000, 16'h0000, 0), 1'b1);
    wait_idle();
  endtask

  // The receiver stops for a long stretch while bytes keep coming, so the
  // frame queue fills and full must hold the sender back.
  task automatic test_back_pressure();
    tx_gap_max     = 0;
    rx_mode        = RX_FREE;
    rx_hold_cycles = 200;
    for (int i = 0; i < 6; i++) begin
      send_frame(make_frame(own_id, FnHolding, 16'(i * 8), 16'd8, 0), 1'b1);
    end
    wait_idle();
  endtask

  // Phases of mostly well-formed requests with random content under varied
  // settings and traffic shapes; some noise and broken frames mixed in.
  task automatic test_random_traffic();
    logic [7:0]  slave;
    logic [15:0] qmax;
    logic [15:0] amax;
    logic        mark;
    for (int phase = 0; phase < 8; phase++) begin
      slave = (phase == 0) ? 8'h00 : (phase == 1) ? 8'hFF : 8'($urandom);
      case (phase % 4)
        0: qmax = 16'hFFFF;
        1: qmax = 16'h0000;
        2: qmax = 16'($urandom);
        default: qmax = 16'($urandom_range(0, 2000));
      endcase
      case (phase % 4)
        0: amax = 16'($urandom);
        1: amax = 16'hFFFF;
        2: amax = 16'h0000;
        default: amax = 16'($urandom_range(16'h8000, 16'hFFFF));
      endcase
      // Every third phase runs without any idling on either side.
      if (phase % 3 == 0) begin
        tx_gap_max = 0;
        rx_mode    = RX_FREE;
      end else begin
        tx_gap_max = $urandom_range(1, 8);
        rx_mode    = (phase % 3 == 1) ? RX_RANDOM : RX_PATTERN;
      end
      apply_settings(slave, qmax, amax);
      for (int n = 0; n < 6; n++) begin
        if (n != 5 && $urandom_range(0, 7) == 0) begin
          send_noise();
        end
        // The closing frame of a phase always carries a start mark, so the
        // frame state is back at its first byte before the next settings.
        mark = (n == 5) || ($urandom_range(0, 9) != 0);
        send_random_request(mark);
      end
    end
    wait_idle();
  endtask

  initial begin
    rst_ni      = 1'b0;
    push        = 1'b0;
    in_item_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_settings();
    test_exception_codes();
    test_ignored_frames();
    test_framing();
    test_setting_extremes();
    test_back_pressure();
    test_random_traffic();

    wait_idle();
    repeat (6) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
